@@ rtl/tbpf_pkg.sv @@
// ----------------------------------------------------------------------------
// tbpf_pkg: shared types and constants of the background pixel fetch block
// Holds the queue entry format, register indexes and configuration bundle.
// ----------------------------------------------------------------------------
package tbpf_pkg;

	localparam int VRAM_BYTES          = 8192;
	localparam int VRAM_AW             = $clog2(VRAM_BYTES);
	localparam int SCREEN_WIDTH_DEF    = 160;
	localparam int SCREEN_HEIGHT_DEF   = 144;
	localparam int QUEUE_DEPTH_DEF     = 4;

	localparam logic [1:0]         MAP_PREFIX      = 2'b11;
	localparam logic [VRAM_AW-1:0] SIGNED_TILE_OFS = 13'h0800;
	localparam logic [7:0]         TILE_SIGN_FLIP  = 8'h80;

	localparam logic [7:0] PALETTE_RESET = 8'd228;

	typedef enum logic [2:0] {
		CFG_BG_ENABLE     = 3'd0,
		CFG_MAP_HIGH      = 3'd1,
		CFG_UNSIGNED_TILE = 3'd2,
		CFG_SCROLL_X      = 3'd3,
		CFG_SCROLL_Y      = 3'd4,
		CFG_BG_PALETTE    = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_FETCH = 2'd1,
		OP_BLANK = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t           kind;
		logic [VRAM_AW-1:0] addr;
		logic [7:0]         wdata;
		logic [2:0]         fine_x;
		logic [2:0]         fine_y;
	} op_t;

	typedef struct packed {
		logic       bg_enable;
		logic       map_high_select;
		logic       unsigned_tile_data;
		logic [7:0] scroll_x;
		logic [7:0] scroll_y;
		logic [7:0] bg_palette;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

@@ rtl/tbpf_front.sv @@
// ----------------------------------------------------------------------------
// tbpf_front: request intake and classification
// Sorts each request into a memory write, a fetch with its tile map address,
// or a blank pixel, and pushes it into the queue.
// ----------------------------------------------------------------------------
module tbpf_front import tbpf_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic [VRAM_AW-1:0] vram_offset,
	input  logic [7:0]         vram_byte,
	input  logic [7:0]         screen_x,
	input  logic [7:0]         screen_y,
	input  cfg_t               cfg,
	input  q_status_t          q_status,
	output logic               push,
	output op_t                entry
);

	localparam logic [8:0] WIDTH_LIM  = 9'(SCREEN_WIDTH);
	localparam logic [8:0] HEIGHT_LIM = 9'(SCREEN_HEIGHT);

	logic [7:0] bx;
	logic [7:0] by;
	logic       off_screen;

	assign in_stall   = q_status.full;
	assign push       = in_valid && !q_status.full;
	assign bx         = screen_x + cfg.scroll_x;
	assign by         = screen_y + cfg.scroll_y;
	assign off_screen = ({1'b0, screen_x} >= WIDTH_LIM) || ({1'b0, screen_y} >= HEIGHT_LIM);

	always_comb begin
		entry.kind   = OP_FETCH;
		entry.addr   = {MAP_PREFIX, cfg.map_high_select, by[7:3], bx[7:3]};
		entry.wdata  = vram_byte;
		entry.fine_x = bx[2:0];
		entry.fine_y = by[2:0];
		if (!command) begin
			entry.kind = OP_WRITE;
			entry.addr = vram_offset;
		end else if (!cfg.bg_enable || off_screen) begin
			entry.kind = OP_BLANK;
		end
	end

endmodule

@@ rtl/tbpf_queue.sv @@
// ----------------------------------------------------------------------------
// tbpf_queue: short request queue between intake and execution
// A small circular buffer of classified requests.
// ----------------------------------------------------------------------------
module tbpf_queue import tbpf_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  op_t       push_entry,
	input  logic      pop,
	output op_t       head,
	output q_status_t q_status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	op_t              entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head           = entries_q[rd_ptr_q];
	assign q_status.full  = (count_q == FULL_CNT);
	assign q_status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/tbpf_back.sv @@
// ----------------------------------------------------------------------------
// tbpf_back: video memory and pixel sequencer
// Executes queued requests on the single-port video memory: a single write per
// write request, three dependent reads per fetch, and drives the result register.
// ----------------------------------------------------------------------------
module tbpf_back import tbpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  op_t        head,
	input  q_status_t  q_status,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] shade,
	output logic [1:0] colour_index,
	output logic       drawn
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_TILE = 4'b0010,
		ST_LO   = 4'b0100,
		ST_HI   = 4'b1000
	} state_t;

	state_t             state_q;
	state_t             state_d;
	logic [7:0]         mem [VRAM_BYTES];
	logic [7:0]         rdata_q;
	logic [7:0]         lo_q;
	logic [2:0]         fine_x_q;
	logic [2:0]         fine_y_q;
	logic [VRAM_AW-1:0] row_q;
	logic [VRAM_AW-1:0] pattern_base;
	logic [VRAM_AW-1:0] mem_addr;
	logic               mem_we;
	logic               mem_re;
	logic               out_free;
	logic               can_take;
	logic               finish;
	logic [1:0]         ci;
	logic [2:0]         bit_sel;
	logic               out_valid_q;
	logic [1:0]         shade_q;
	logic [1:0]         ci_q;
	logic               drawn_q;

	assign out_free = !out_valid_q || !out_stall;
	assign finish   = (state_q == ST_HI) && out_free;
	assign can_take = (state_q == ST_IDLE) || finish;
	assign pop      = can_take && !q_status.empty &&
	                  ((head.kind != OP_BLANK) || ((state_q == ST_IDLE) && out_free));

	always_comb begin
		if (cfg.unsigned_tile_data) begin
			pattern_base = {1'b0, rdata_q, 4'b0000};
		end else begin
			pattern_base = SIGNED_TILE_OFS + {1'b0, rdata_q ^ TILE_SIGN_FLIP, 4'b0000};
		end
	end

	always_comb begin
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = head.addr;
		state_d  = state_q;
		case (state_q)
			ST_IDLE, ST_HI: begin
				if (pop && (head.kind == OP_WRITE)) begin
					mem_we = 1'b1;
				end
				if (pop && (head.kind == OP_FETCH)) begin
					mem_re  = 1'b1;
					state_d = ST_TILE;
				end else if (finish) begin
					state_d = ST_IDLE;
				end
			end
			ST_TILE: begin
				mem_re   = 1'b1;
				mem_addr = pattern_base | {{(VRAM_AW-4){1'b0}}, fine_y_q, 1'b0};
				state_d  = ST_LO;
			end
			ST_LO: begin
				mem_re   = 1'b1;
				mem_addr = row_q | {{(VRAM_AW-1){1'b0}}, 1'b1};
				state_d  = ST_HI;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= head.wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			fine_x_q <= head.fine_x;
			fine_y_q <= head.fine_y;
		end
		if (state_q == ST_TILE) begin
			row_q <= mem_addr;
		end
		if (state_q == ST_LO) begin
			lo_q <= rdata_q;
		end
	end

	assign bit_sel = 3'd7 - fine_x_q;
	assign ci      = {rdata_q[bit_sel], lo_q[bit_sel]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish || (pop && (head.kind == OP_BLANK))) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			shade_q <= cfg.bg_palette[{ci, 1'b0} +: 2];
			ci_q    <= ci;
			drawn_q <= 1'b1;
		end else if (pop && (head.kind == OP_BLANK)) begin
			shade_q <= 2'd0;
			ci_q    <= 2'd0;
			drawn_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign shade        = shade_q;
	assign colour_index = ci_q;
	assign drawn        = drawn_q;

endmodule

@@ rtl/tile_background_pixel_fetch_core.sv @@
// ----------------------------------------------------------------------------
// tile_background_pixel_fetch_core: tile map background pixel fetch
// A fetch makes three reads on the single video memory port (map entry, low
// plane, high plane), then registers its result once the output slot is free.
// A write needs only the memory port; a blank pixel takes only the output slot.
// Reset clears the control state and loads the register defaults; video
// memory is not cleared and holds unknown data until written.
// ----------------------------------------------------------------------------
module tile_background_pixel_fetch_core import tbpf_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
	parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic [VRAM_AW-1:0] vram_offset,
	input  logic [7:0]         vram_byte,
	input  logic [7:0]         screen_x,
	input  logic [7:0]         screen_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         shade,
	output logic [1:0]         colour_index,
	output logic               drawn
);

	cfg_t      cfg_q;
	op_t       push_entry;
	op_t       head;
	q_status_t q_status;
	logic      push;
	logic      pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bg_enable          <= 1'b1;
			cfg_q.map_high_select    <= 1'b0;
			cfg_q.unsigned_tile_data <= 1'b1;
			cfg_q.scroll_x           <= 8'd0;
			cfg_q.scroll_y           <= 8'd0;
			cfg_q.bg_palette         <= PALETTE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BG_ENABLE:     cfg_q.bg_enable          <= cfg_data[0];
				CFG_MAP_HIGH:      cfg_q.map_high_select    <= cfg_data[0];
				CFG_UNSIGNED_TILE: cfg_q.unsigned_tile_data <= cfg_data[0];
				CFG_SCROLL_X:      cfg_q.scroll_x           <= cfg_data;
				CFG_SCROLL_Y:      cfg_q.scroll_y           <= cfg_data;
				CFG_BG_PALETTE:    cfg_q.bg_palette         <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tbpf_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.vram_offset (vram_offset),
		.vram_byte   (vram_byte),
		.screen_x    (screen_x),
		.screen_y    (screen_y),
		.cfg         (cfg_q),
		.q_status    (q_status),
		.push        (push),
		.entry       (push_entry)
	);

	tbpf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_status   (q_status)
	);

	tbpf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.shade        (shade),
		.colour_index (colour_index),
		.drawn        (drawn)
	);

	// An accepted request is still queued right after the edge that took it.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !q_status.empty)
		else $error("accepted request missing from queue");

	// A pixel that is not drawn always carries zero shade and index.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !drawn |-> (shade == 2'd0) && (colour_index == 2'd0))
		else $error("undrawn pixel with nonzero payload");

	// The back end never pops an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty queue");

endmodule

@@ tb/sv/pixel_fetch_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_fetch_checker: predicts and checks background pixel responses
// Watches the register port and the request and response channels, keeps its own copy of
// the video memory and the register settings, works out the expected pixel
// for every fetch request and compares each response field against it.
// ----------------------------------------------------------------------------
module pixel_fetch_checker import tbpf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               command,
	input  logic [VRAM_AW-1:0] vram_offset,
	input  logic [7:0]         vram_byte,
	input  logic [7:0]         screen_x,
	input  logic [7:0]         screen_y,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         shade,
	input  logic [1:0]         colour_index,
	input  logic               drawn,
	output int                 mismatches,
	output int                 outstanding
);

	typedef struct packed {
		logic [1:0] shade;
		logic [1:0] colour_index;
		logic       drawn;
	} pixel_t;

	logic [7:0] vram_copy [VRAM_BYTES];
	cfg_t       regs;
	pixel_t     pending_pixels [$];
	pixel_t     want;
	int         fail_cnt;

	function automatic pixel_t predict_pixel(input logic [7:0] x, input logic [7:0] y);
		logic [7:0]         bx;
		logic [7:0]         by;
		logic [7:0]         tile;
		logic [7:0]         lo;
		logic [7:0]         hi;
		logic [VRAM_AW-1:0] row;
		logic [2:0]         b;
		pixel_t             p;
		p = '0;
		if (!regs.bg_enable || x >= SCREEN_WIDTH_DEF || y >= SCREEN_HEIGHT_DEF) begin
			return p;
		end
		bx = x + regs.scroll_x;
		by = y + regs.scroll_y;
		tile = vram_copy[13'h1800 + (regs.map_high_select ? 13'h0400 : 13'h0000) +
			13'({by[7:3], bx[7:3]})];
		if (regs.unsigned_tile_data) begin
			row = 13'({tile, 4'h0});
		end else begin
			row = 13'h0800 + 13'({tile ^ 8'h80, 4'h0});
		end
		row = row + 13'({by[2:0], 1'b0});
		lo = vram_copy[row];
		hi = vram_copy[row + 13'd1];
		b = 3'd7 - bx[2:0];
		p.colour_index = {hi[b], lo[b]};
		p.shade = regs.bg_palette[{p.colour_index, 1'b0} +: 2];
		p.drawn = 1'b1;
		return p;
	endfunction

	task automatic check_field(input string name, input logic [1:0] exp_val,
			input logic [1:0] act_val);
		if (act_val !== exp_val) begin
			fail_cnt++;
			if (fail_cnt <= 40) begin
				$display("%0t: %s expected %0d got %0d", $time, name, exp_val, act_val);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{bg_enable: 1'b1, map_high_select: 1'b0, unsigned_tile_data: 1'b1,
				scroll_x: 8'd0, scroll_y: 8'd0, bg_palette: PALETTE_RESET};
			pending_pixels.delete();
			fail_cnt = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_BG_ENABLE:     regs.bg_enable = cfg_data[0];
					CFG_MAP_HIGH:      regs.map_high_select = cfg_data[0];
					CFG_UNSIGNED_TILE: regs.unsigned_tile_data = cfg_data[0];
					CFG_SCROLL_X:      regs.scroll_x = cfg_data;
					CFG_SCROLL_Y:      regs.scroll_y = cfg_data;
					CFG_BG_PALETTE:    regs.bg_palette = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pending_pixels.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 40) begin
						$display("%0t: pixel expected none got shade %0d colour_index %0d drawn %0d",
							$time, shade, colour_index, drawn);
					end
				end else begin
					want = pending_pixels.pop_front();
					check_field("shade", want.shade, shade);
					check_field("colour_index", want.colour_index, colour_index);
					check_field("drawn", 2'(want.drawn), 2'(drawn));
				end
			end
			if (in_valid && !in_stall) begin
				if (command == 1'(OP_WRITE)) begin
					vram_copy[vram_offset] = vram_byte;
				end else begin
					pending_pixels.push_back(predict_pixel(screen_x, screen_y));
				end
			end
			mismatches <= fail_cnt;
			outstanding <= pending_pixels.size();
		end
	end

endmodule

@@ tb/sv/tile_background_pixel_fetch_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_background_pixel_fetch_core_tb: stimulus and verdict for the core
// Fills video memory on demand so that every fetch reads written bytes only,
// walks through directed corner cases and then random register settings with
// mixed write and fetch requests, random gaps and random output stalls.
// ----------------------------------------------------------------------------
module tile_background_pixel_fetch_core_tb import tbpf_pkg::*;;

	localparam int         ITEMS       = 1550;
	localparam int         PHASES      = 10;
	localparam int         STALL_LIMIT = 4000;
	localparam logic [2:0] CFG_SPARE_6 = 3'd6;
	localparam logic [2:0] CFG_SPARE_7 = 3'd7;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [7:0]         cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               command = 1'b0;
	logic [VRAM_AW-1:0] vram_offset = '0;
	logic [7:0]         vram_byte = '0;
	logic [7:0]         screen_x = '0;
	logic [7:0]         screen_y = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         shade;
	logic [1:0]         colour_index;
	logic               drawn;
	int                 mismatches;
	int                 outstanding;

	logic       quiet = 1'b0;
	logic [7:0] vram_mirror [VRAM_BYTES];
	bit         vram_written [VRAM_BYTES];
	cfg_t       stim_cfg = '{bg_enable: 1'b1, map_high_select: 1'b0, unsigned_tile_data: 1'b1,
		scroll_x: 8'd0, scroll_y: 8'd0, bg_palette: PALETTE_RESET};
	int         requests_sent = 0;
	int         writes_sent = 0;
	int         settings_applied = 0;
	int         idle_cycles = 0;

	always #6 clk = ~clk;

	tile_background_pixel_fetch_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .command(command),
		.vram_offset(vram_offset), .vram_byte(vram_byte),
		.screen_x(screen_x), .screen_y(screen_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.shade(shade), .colour_index(colour_index), .drawn(drawn)
	);

	pixel_fetch_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .command(command),
		.vram_offset(vram_offset), .vram_byte(vram_byte),
		.screen_x(screen_x), .screen_y(screen_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.shade(shade), .colour_index(colour_index), .drawn(drawn),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < 7);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no request accepted for %0d cycles", $time, idle_cycles);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	function automatic logic [VRAM_AW-1:0] map_entry_addr(input logic [7:0] x,
			input logic [7:0] y);
		logic [7:0] bx;
		logic [7:0] by;
		bx = x + stim_cfg.scroll_x;
		by = y + stim_cfg.scroll_y;
		return 13'h1800 + (stim_cfg.map_high_select ? 13'h0400 : 13'h0000) +
			13'({by[7:3], bx[7:3]});
	endfunction

	function automatic logic [VRAM_AW-1:0] pattern_row_addr(input logic [7:0] y,
			input logic [7:0] tile);
		logic [7:0] by;
		by = y + stim_cfg.scroll_y;
		if (stim_cfg.unsigned_tile_data) begin
			return 13'({tile, 4'h0}) + 13'({by[2:0], 1'b0});
		end
		return 13'h0800 + 13'({tile ^ 8'h80, 4'h0}) + 13'({by[2:0], 1'b0});
	endfunction

	task automatic send_request(input logic cmd, input logic [VRAM_AW-1:0] ofs,
			input logic [7:0] byt, input logic [7:0] x, input logic [7:0] y);
		while (!quiet && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		vram_offset <= ofs;
		vram_byte <= byt;
		screen_x <= x;
		screen_y <= y;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		requests_sent++;
	endtask

	task automatic vram_write(input logic [VRAM_AW-1:0] ofs, input logic [7:0] byt);
		send_request(1'(OP_WRITE), ofs, byt, 8'($urandom), 8'($urandom));
		vram_mirror[ofs] = byt;
		vram_written[ofs] = 1'b1;
		writes_sent++;
	endtask

	// The bytes a drawn fetch will read are written first if they never were.
	task automatic fetch_pixel(input logic [7:0] x, input logic [7:0] y);
		logic [VRAM_AW-1:0] ma;
		logic [VRAM_AW-1:0] ra;
		if (stim_cfg.bg_enable && x < SCREEN_WIDTH_DEF && y < SCREEN_HEIGHT_DEF) begin
			ma = map_entry_addr(x, y);
			if (!vram_written[ma]) vram_write(ma, 8'($urandom));
			ra = pattern_row_addr(y, vram_mirror[ma]);
			if (!vram_written[ra]) vram_write(ra, 8'($urandom));
			if (!vram_written[ra + 13'd1]) vram_write(ra + 13'd1, 8'($urandom));
		end
		send_request(1'(OP_FETCH), 13'($urandom), 8'($urandom), x, y);
	endtask

	task automatic set_register(input logic [2:0] idx, input logic [7:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic apply_config(input cfg_t c);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		set_register(CFG_BG_ENABLE, 8'(c.bg_enable) | (8'($urandom) & 8'hFE));
		set_register(CFG_MAP_HIGH, 8'(c.map_high_select) | (8'($urandom) & 8'hFE));
		set_register(CFG_UNSIGNED_TILE, 8'(c.unsigned_tile_data) | (8'($urandom) & 8'hFE));
		set_register(CFG_SCROLL_X, c.scroll_x);
		set_register(CFG_SCROLL_Y, c.scroll_y);
		set_register(CFG_BG_PALETTE, c.bg_palette);
		set_register($urandom_range(1) ? CFG_SPARE_6 : CFG_SPARE_7, 8'($urandom));
		cfg_we <= 1'b0;
		stim_cfg = c;
		settings_applied++;
	endtask

	initial begin
		cfg_t               c;
		int                 directed;
		logic [VRAM_AW-1:0] ofs;
		logic [7:0]         x;
		logic [7:0]         y;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		vram_write(13'h1FFF, 8'hFF);
		vram_write(13'h0000, 8'h00);
		fetch_pixel(8'd0, 8'd0);
		fetch_pixel(8'd159, 8'd143);
		fetch_pixel(8'd160, 8'd0);
		fetch_pixel(8'd0, 8'd144);
		fetch_pixel(8'd255, 8'd255);

		c = stim_cfg;
		c.bg_enable = 1'b0;
		apply_config(c);
		fetch_pixel(8'd10, 8'd10);

		// Signed tile numbers on the upper map with scrolling that wraps both axes.
		c = '{bg_enable: 1'b1, map_high_select: 1'b1, unsigned_tile_data: 1'b0,
			scroll_x: 8'd255, scroll_y: 8'd255, bg_palette: 8'h1B};
		apply_config(c);
		vram_write(map_entry_addr(8'd1, 8'd1), 8'h80);
		fetch_pixel(8'd1, 8'd1);
		vram_write(map_entry_addr(8'd159, 8'd143), 8'h7F);
		fetch_pixel(8'd159, 8'd143);
		directed = requests_sent;

		for (int p = 0; p < PHASES; p++) begin
			c.bg_enable = ($urandom_range(9) != 0);
			c.map_high_select = 1'($urandom_range(1));
			c.unsigned_tile_data = 1'($urandom_range(1));
			c.scroll_x = 8'($urandom);
			c.scroll_y = 8'($urandom);
			c.bg_palette = 8'($urandom);
			if (p == 0) begin
				c = '{bg_enable: 1'b1, map_high_select: 1'b0, unsigned_tile_data: 1'b0,
					scroll_x: 8'd0, scroll_y: 8'd0, bg_palette: 8'h00};
			end else if (p == 1) begin
				c = '{bg_enable: 1'b1, map_high_select: 1'b1, unsigned_tile_data: 1'b1,
					scroll_x: 8'd255, scroll_y: 8'd255, bg_palette: 8'hFF};
			end
			apply_config(c);
			quiet <= (p == 4 || p == 5);
			while (requests_sent < directed + (p + 1) * (ITEMS - directed) / PHASES) begin
				if ($urandom_range(3) == 0) begin
					case ($urandom_range(4))
						0, 1:    ofs = 13'h1800 + 13'($urandom_range(2047));
						2, 3:    ofs = 13'($urandom_range(13'h17FF));
						default: ofs = 13'($urandom);
					endcase
					vram_write(ofs, 8'($urandom));
				end else begin
					x = ($urandom_range(99) < 85) ? 8'($urandom_range(159)) : 8'($urandom);
					y = ($urandom_range(99) < 85) ? 8'($urandom_range(143)) : 8'($urandom);
					fetch_pixel(x, y);
				end
			end
		end

		in_valid <= 1'b0;
		quiet <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("Sent %0d requests: %0d video memory writes and %0d pixel fetches.",
			requests_sent, writes_sent, requests_sent - writes_sent);
		$display("Covered %0d register settings, both maps, both tile modes and scroll wrap.",
			settings_applied);
		if (mismatches == 0 && outstanding == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
